// ===== sv/delimited_frame_receiver_macros.svh =====
// Assertion helpers used by delimited_frame_receiver.
`ifndef DELIMITED_FRAME_RECEIVER_MACROS_SVH
`define DELIMITED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DFR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DFR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/dfr_pkg.sv =====
package dfr_pkg;

	localparam int MAX_FRAME = 1024;               // 8 .. 2047 (frame_byte_count is FBC_W = 11 bits)
	localparam int CNT_W     = $clog2(MAX_FRAME + 1);
	localparam int POS_W     = 10;
	localparam int FBC_W     = 11;
	localparam int WORD_W    = 32;
	localparam int BYTE_W    = 8;
	localparam int POS_MAX   = (1 << POS_W) - 1;

	localparam logic [BYTE_W-1:0] DELIM = 8'hc0;

	// queue between parser and result builder; depth is a power of two
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// output tdata: payload_byte, byte_position, frame_status, command_number,
	// frame_byte_count from bit 0 up, padded to 64 bits
	localparam int TDATA_W = 64;

	typedef enum logic [1:0] {
		MODE_HUNT,
		MODE_SKIP,
		MODE_COLLECT
	} dfr_mode_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_MISMATCH,
		ST_SHORT,
		ST_OVERFLOW
	} dfr_status_t;

	typedef enum logic {
		OP_DATA,
		OP_END
	} dfr_kind_t;

	typedef struct packed {
		dfr_kind_t         kind;
		logic              first;   // first payload byte of a frame
		logic [BYTE_W-1:0] data;
	} dfr_op_t;

endpackage

// ===== sv/dfr_front.sv =====
module dfr_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [7:0]             in_byte,
	output logic                   push,
	output dfr_pkg::dfr_op_t       op
);
	import dfr_pkg::*;

	dfr_mode_t mode_q, mode_d;
	logic      take;
	logic      is_delim;

	assign take     = in_valid & in_ready;
	assign is_delim = (in_byte == DELIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HUNT;
		end else if (take) begin
			mode_q <= mode_d;
		end
	end

	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			MODE_HUNT:    mode_d = is_delim ? MODE_SKIP : MODE_HUNT;
			MODE_SKIP:    mode_d = is_delim ? MODE_SKIP : MODE_COLLECT;
			MODE_COLLECT: mode_d = is_delim ? MODE_HUNT : MODE_COLLECT;
			default:      mode_d = is_delim ? MODE_SKIP : MODE_HUNT;
		endcase
	end

	always_comb begin
		push     = 1'b0;
		op.kind  = OP_DATA;
		op.first = 1'b0;
		op.data  = in_byte;
		case (mode_q)
			MODE_SKIP: begin
				push     = take & ~is_delim;
				op.first = 1'b1;
			end
			MODE_COLLECT: begin
				push    = take;
				op.kind = is_delim ? OP_END : OP_DATA;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

endmodule

// ===== sv/dfr_fifo.sv =====
module dfr_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  dfr_pkg::dfr_op_t              push_op,
	input  logic                          pop,
	output dfr_pkg::dfr_op_t              head_op,
	output logic                          not_empty,
	output logic                          full,
	output logic [dfr_pkg::QCNT_W-1:0]    count
);
	import dfr_pkg::*;

	dfr_op_t             slot_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push, do_pop;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;
	assign head_op   = slot_q[rd_ptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/dfr_back.sv =====
module dfr_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           op_valid,
	input  dfr_pkg::dfr_op_t               op,
	output logic                           op_pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [dfr_pkg::TDATA_W-1:0]    out_data,
	output logic                           out_end
);
	import dfr_pkg::*;

	localparam int USED_W = BYTE_W + POS_W + 2 + WORD_W + FBC_W;

	logic [CNT_W-1:0]   count_q;
	logic [WORD_W-1:0]  length_q, command_q;
	logic               ovf_q;

	logic [CNT_W-1:0]   idx;
	logic [WORD_W-1:0]  length_cur, command_cur;
	logic [WORD_W-1:0]  length_nxt, command_nxt;
	logic               ovf_cur;
	logic [POS_W-1:0]   pos;
	dfr_status_t        status;

	logic               valid_q;
	logic               end_q;
	logic [USED_W-1:0]  data_q;

	assign op_pop    = op_valid & (~valid_q | out_ready);
	assign out_valid = valid_q;
	assign out_end   = end_q;
	assign out_data  = TDATA_W'(data_q);

	// a first byte starts from cleared frame state
	assign idx         = op.first ? '0 : count_q;
	assign length_cur  = op.first ? '0 : length_q;
	assign command_cur = op.first ? '0 : command_q;
	assign ovf_cur     = op.first ? 1'b0 : ovf_q;
	assign pos         = (32'(idx) > 32'(POS_MAX)) ? POS_W'(POS_MAX) : POS_W'(idx);

	always_comb begin
		length_nxt  = length_cur;
		command_nxt = command_cur;
		if (32'(idx) < 32'd4) begin
			length_nxt[8*idx[1:0] +: 8] = op.data;
		end else if (32'(idx) < 32'd8) begin
			command_nxt[8*idx[1:0] +: 8] = op.data;
		end
	end

	always_comb begin
		if (ovf_q) begin
			status = ST_OVERFLOW;
		end else if (32'(count_q) < 32'd4) begin
			status = ST_SHORT;
		end else if (length_q != WORD_W'(count_q)) begin
			status = ST_MISMATCH;
		end else begin
			status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			length_q  <= '0;
			command_q <= '0;
			ovf_q     <= 1'b0;
		end else if (op_pop && op.kind == OP_DATA) begin
			length_q  <= length_nxt;
			command_q <= command_nxt;
			if (32'(idx) >= 32'(MAX_FRAME)) begin
				ovf_q   <= 1'b1;
				count_q <= idx;
			end else begin
				ovf_q   <= ovf_cur;
				count_q <= idx + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op_pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			end_q <= (op.kind == OP_END);
			if (op.kind == OP_END) begin
				data_q <= {FBC_W'(32'(count_q)), command_q, status, POS_W'(0), BYTE_W'(0)};
			end else begin
				data_q <= {FBC_W'(0), WORD_W'(0), ST_OK, pos, op.data};
			end
		end
	end

endmodule

// ===== sv/delimited_frame_receiver.sv =====
// channel  dir  tdata                                      tuser
// s_axis   in   [7:0] rx_byte                              -
// m_axis   out  [7:0] payload_byte, [17:8] byte_position,  [0] is_frame_end
//               [19:18] frame_status, [51:20] command_number,
//               [62:52] frame_byte_count, [63] zero
//
// One byte per clock in, one result per clock out, sustained while m_axis_tready stays high.
// On its way out a byte is written by the parser into a 4-entry queue and
// then into the result builder's output register.
// Delimiters that only open or repeat leave the queue untouched.
// s_axis_tready drops only when the queue is full under a stalled m_axis.
// arst_n clears the parser to hunting, empties the queue and the output.
module delimited_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // payload_byte, byte_position, frame_status,
	                                    // command_number, frame_byte_count
	output logic        m_axis_tuser    // [0] is_frame_end
);
	import dfr_pkg::*;

	`include "delimited_frame_receiver_macros.svh"

	dfr_op_t            push_op, head_op;
	logic               push, pop;
	logic               q_not_empty, q_full;
	logic [QCNT_W-1:0]  q_count;
	logic               end_ok;

	assign s_axis_tready = ~q_full;
	assign end_ok        = m_axis_tvalid && m_axis_tuser && (m_axis_tdata[19:18] == ST_OK);

	dfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.push     (push),
		.op       (push_op)
	);

	dfr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.pop       (pop),
		.head_op   (head_op),
		.not_empty (q_not_empty),
		.full      (q_full),
		.count     (q_count)
	);

	dfr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (q_not_empty),
		.op        (head_op),
		.op_pop    (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_end   (m_axis_tuser)
	);

	`DFR_ASSERT_NOW(a_q_bound, 1'b1, q_count <= QCNT_W'(QDEPTH), "queue count beyond depth")
	`DFR_ASSERT_NOW(a_pop_nonempty, pop, q_count != '0, "pop from empty queue")
	`DFR_ASSERT_NEXT(a_drain, q_not_empty && !m_axis_tvalid, m_axis_tvalid, "queue not drained")
	`DFR_ASSERT_NOW(a_ok_len, end_ok, m_axis_tdata[62:52] >= 11'd4, "ok status on short frame")

endmodule
